@@ rtl/kdslp_pkg.sv @@
// Shared types and constants for the key debounce and press detector.
`timescale 1ns / 1ps
package kdslp_pkg;

    localparam int NUM_KEYS  = 3;
    localparam int TIME_BITS = 32;
    localparam int HOLD_BITS = 16;
    localparam int DEB_BITS  = 16;
    localparam int KEY_W     = 2;
    localparam int KIND_W    = 2;

    localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [NUM_KEYS-1:0] RELEASE_MASK_RESET = 3'd2;

    // Event codes
    typedef enum logic [KIND_W-1:0] {
        KIND_SHORT   = 2'd0,
        KIND_LONG    = 2'd1,
        KIND_RELEASE = 2'd2
    } evt_kind_t;

    // Register indexes on the configuration port
    typedef enum logic {
        REG_DEBOUNCE     = 1'b0,
        REG_RELEASE_MASK = 1'b1
    } reg_idx_t;

    // One poll sample
    typedef struct packed {
        logic [TIME_BITS-1:0] time_ms;
        logic [NUM_KEYS-1:0]  raw_pressed;
        logic [HOLD_BITS-1:0] hold_ms_key0;
        logic [HOLD_BITS-1:0] hold_ms_key1;
        logic [HOLD_BITS-1:0] hold_ms_key2;
    } sample_t;

    // One result item
    typedef struct packed {
        logic [KEY_W-1:0]  key_index;
        logic [KIND_W-1:0] event_kind;
        logic              last_event;
    } evt_t;

    // What one lane found for the current sample
    typedef struct packed {
        logic      valid;
        evt_kind_t kind;
    } lane_evt_t;

    // Configuration seen by the lanes
    typedef struct packed {
        logic [DEB_BITS-1:0] settle_ms;
        logic [NUM_KEYS-1:0] release_mask;
    } cfg_t;

endpackage

@@ rtl/kdslp_regs.sv @@
// APB-style configuration registers.
`timescale 1ns / 1ps
module kdslp_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output kdslp_pkg::cfg_t   cfg
);
    import kdslp_pkg::*;

    logic [DEB_BITS-1:0] debounce_reg;
    logic [NUM_KEYS-1:0] mask_reg;
    logic                wr_en;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            mask_reg     <= RELEASE_MASK_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DEBOUNCE:     debounce_reg <= pwdata[DEB_BITS-1:0];
                REG_RELEASE_MASK: mask_reg     <= pwdata[NUM_KEYS-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_DEBOUNCE:     prdata = {{(32-DEB_BITS){1'b0}}, debounce_reg};
            REG_RELEASE_MASK: prdata = {{(32-NUM_KEYS){1'b0}}, mask_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.settle_ms    = debounce_reg;
    assign cfg.release_mask = mask_reg;

endmodule

@@ rtl/kdslp_lane.sv @@
// One key lane: debounce, press timing and event decision.
`timescale 1ns / 1ps
module kdslp_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [kdslp_pkg::TIME_BITS-1:0]   now,
    input  logic                              down,
    input  logic [kdslp_pkg::HOLD_BITS-1:0]   hold_in,
    input  logic [kdslp_pkg::DEB_BITS-1:0]    settle_ms,
    input  logic                              release_en,
    output kdslp_pkg::lane_evt_t              evt
);
    import kdslp_pkg::*;

    logic                 raw_level_reg, raw_level_next;
    logic                 stable_reg, stable_next;
    logic [TIME_BITS-1:0] raw_time_reg, raw_time_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic [HOLD_BITS-1:0] hold_reg, hold_next;
    logic                 long_done_reg, long_done_next;

    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] held;
    logic                 keep;

    // Debounce and press decision for this sample
    always_comb
    begin
        raw_level_next  = raw_level_reg;
        raw_time_next   = raw_time_reg;
        stable_next     = stable_reg;
        press_time_next = press_time_reg;
        hold_next       = hold_reg;
        long_done_next  = long_done_reg;
        evt.valid       = 1'b0;
        evt.kind        = KIND_SHORT;

        if (down != raw_level_reg)
        begin
            raw_level_next = down;
            raw_time_next  = now;
        end
        since = now - raw_time_next;
        held  = now - press_time_reg;
        keep  = (down == stable_reg) ||
                (since < {{(TIME_BITS-DEB_BITS){1'b0}}, settle_ms});

        if (keep)
        begin
            // held key: one long event once the threshold is reached
            if (stable_reg && !long_done_reg &&
                (held >= {{(TIME_BITS-HOLD_BITS){1'b0}}, hold_reg}))
            begin
                long_done_next = 1'b1;
                evt.valid      = 1'b1;
                evt.kind       = KIND_LONG;
            end
        end
        else
        begin
            stable_next = down;
            if (down)
            begin
                press_time_next = now;
                hold_next       = hold_in;
                long_done_next  = 1'b0;
            end
            else if (long_done_reg)
            begin
                evt.valid = release_en;
                evt.kind  = KIND_RELEASE;
            end
            else
            begin
                evt.valid = 1'b1;
                evt.kind  = KIND_SHORT;
            end
        end
    end

    // Key state, updated on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_level_reg  <= 1'b0;
            stable_reg     <= 1'b0;
            raw_time_reg   <= '0;
            press_time_reg <= '0;
            hold_reg       <= '0;
            long_done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            raw_level_reg  <= raw_level_next;
            stable_reg     <= stable_next;
            raw_time_reg   <= raw_time_next;
            press_time_reg <= press_time_next;
            hold_reg       <= hold_next;
            long_done_reg  <= long_done_next;
        end
    end

endmodule

@@ rtl/kdslp_merge.sv @@
// Merge stage: holds the lane events of one item and sends them one per cycle unless stalled.
`timescale 1ns / 1ps
module kdslp_merge (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        load,
    input  kdslp_pkg::lane_evt_t [kdslp_pkg::NUM_KEYS-1:0] lane_evt,
    output logic                                        take_ok,
    output logic                                        evt_valid,
    input  logic                                        evt_stall,
    output kdslp_pkg::evt_t                             evt
);
    import kdslp_pkg::*;

    logic [NUM_KEYS-1:0] pend_reg;
    evt_kind_t           kind_reg [NUM_KEYS];
    logic                out_valid_reg;
    evt_t                out_reg;

    logic [NUM_KEYS-1:0] low_bit;
    logic [KEY_W-1:0]    low_idx;
    logic                any_pend;
    logic                pop;
    logic                pop_last;
    logic                out_ready;
    logic                found;

    // Lowest pending key goes first
    always_comb
    begin
        low_bit = '0;
        low_idx = '0;
        found   = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (pend_reg[i] && !found)
            begin
                found      = 1'b1;
                low_bit[i] = 1'b1;
                low_idx    = KEY_W'(i);
            end
        end
    end

    assign any_pend  = |pend_reg;
    assign out_ready = !out_valid_reg || !evt_stall;
    assign pop       = any_pend && out_ready;
    assign pop_last  = (pend_reg & ~low_bit) == '0;
    assign take_ok   = !any_pend || (pop && pop_last);

    // Pending events of the current item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (load)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                pend_reg[i] <= lane_evt[i].valid;
            end
        end
        else if (pop)
        begin
            pend_reg <= pend_reg & ~low_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                kind_reg[i] <= lane_evt[i].kind;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.key_index  <= low_idx;
            out_reg.event_kind <= kind_reg[low_idx];
            out_reg.last_event <= pop_last;
        end
    end

    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    // Checks
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped event not presented");

    a_keep_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !pop_last && !load) |=> any_pend)
        else $error("pending events lost");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load && any_pend) |-> (pop && pop_last))
        else $error("item loaded over pending events");

endmodule

@@ rtl/key_debounce_short_long_press.sv @@
// Top level of the three-key debouncer with short and long press events.
// An event is registered in pend_reg, then in the merge output register.
// A new item is accepted only while the merge stage is empty or pops its last event;
//   the single merge output register sends one event per cycle when not stalled.
// Reset: every key released with zero times, debounce time 30 ms, release_event_mask 2.
// All keys are evaluated side by side and updated together at the accept edge.
`timescale 1ns / 1ps
module key_debounce_short_long_press (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  kdslp_pkg::sample_t   sample,
    output logic                 evt_valid,
    input  logic                 evt_stall,
    output kdslp_pkg::evt_t      evt,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import kdslp_pkg::*;

    cfg_t                           cfg;
    lane_evt_t [NUM_KEYS-1:0]       lane_evt;
    logic [HOLD_BITS-1:0]           hold_in [NUM_KEYS];
    logic                           take_ok;
    logic                           accept;

    assign sample_stall = !take_ok;
    assign accept       = sample_valid && take_ok;

    assign hold_in[0] = sample.hold_ms_key0;
    assign hold_in[1] = sample.hold_ms_key1;
    assign hold_in[2] = sample.hold_ms_key2;

    kdslp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // One lane per key
    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_lane
        kdslp_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .accept      (accept),
            .now         (sample.time_ms),
            .down        (sample.raw_pressed[g]),
            .hold_in     (hold_in[g]),
            .settle_ms   (cfg.settle_ms),
            .release_en  (cfg.release_mask[g]),
            .evt         (lane_evt[g])
        );
    end

    kdslp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .lane_evt  (lane_evt),
        .take_ok   (take_ok),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule
